FILE: rtl/iirdf2_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_pkg
// shared types, constants and register map of the direct form II iir filter
// ----------------------------------------------------------------------------
package iirdf2_pkg;

  // filter order, 1 to 3
  localparam int ORDER     = 3;

  // data formats
  localparam int SAMPLE_W  = 16;
  localparam int COEF_W    = 24;
  localparam int STATE_W   = 24;
  localparam int FRAC_BITS = 20;
  localparam int PROD_W    = COEF_W + STATE_W;
  localparam int ACC_W     = PROD_W + 2;
  localparam int RND_W     = ACC_W - FRAC_BITS;
  localparam int HALF_LSB  = 1 << (FRAC_BITS - 1);

  // saturation limits
  localparam int W_MAX     = (1 << (STATE_W - 1)) - 1;
  localparam int W_MIN     = -(1 << (STATE_W - 1));
  localparam int Y_MAX     = (1 << (SAMPLE_W - 1)) - 1;
  localparam int Y_MIN     = -(1 << (SAMPLE_W - 1));

  // coefficient banks
  localparam int NUM_B     = 4;
  localparam int NUM_A     = 3;
  localparam int IDX_W     = $clog2(ORDER + 1);

  // apb register map
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_COEF_B0 = 3'd0,
    REG_COEF_B1 = 3'd1,
    REG_COEF_B2 = 3'd2,
    REG_COEF_B3 = 3'd3,
    REG_COEF_A1 = 3'd4,
    REG_COEF_A2 = 3'd5,
    REG_COEF_A3 = 3'd6
  } reg_idx_t;

  localparam logic [COEF_W-1:0] COEF_B0_RST = COEF_W'(1 << FRAC_BITS);

  typedef logic [NUM_B-1:0][COEF_W-1:0] coef_bank_b_t;
  typedef logic [NUM_A-1:0][COEF_W-1:0] coef_bank_a_t;

  // a[0] holds a1, a[1] holds a2, a[2] holds a3
  typedef struct packed {
    coef_bank_b_t b;
    coef_bank_a_t a;
  } coef_set_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FB,
    ST_FB_END,
    ST_W0,
    ST_FF,
    ST_FF_END,
    ST_DONE
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic             load;
    logic             acc_clr;
    logic             mul_en;
    logic             fb_sel;
    logic [IDX_W-1:0] tap_idx;
    logic             w0_en;
    logic             done_en;
  } dp_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;
  } dp_stat_t;

endpackage

`default_nettype wire

FILE: rtl/iirdf2_regs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_regs
// apb coefficient registers, sign-extended read back
// ----------------------------------------------------------------------------
module iirdf2_regs import iirdf2_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output      logic [PDATA_W-1:0]  prdata,
  output      logic                pready,
  output      coef_set_t           coefs
);

  coef_set_t             coef_r;
  coef_set_t             coef_nxt;
  logic                  wr_en;
  logic [REG_IDX_W-1:0]  reg_idx;
  logic [COEF_W-1:0]     wr_val;
  logic [COEF_W-1:0]     rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[PADDR_W-1:2];
  assign wr_val  = pwdata[COEF_W-1:0];

  // register write decode
  always_comb begin
    coef_nxt = coef_r;
    if (wr_en) begin
      unique case (reg_idx)
        REG_COEF_B0: coef_nxt.b[0] = wr_val;
        REG_COEF_B1: coef_nxt.b[1] = wr_val;
        REG_COEF_B2: coef_nxt.b[2] = wr_val;
        REG_COEF_B3: coef_nxt.b[3] = wr_val;
        REG_COEF_A1: coef_nxt.a[0] = wr_val;
        REG_COEF_A2: coef_nxt.a[1] = wr_val;
        REG_COEF_A3: coef_nxt.a[2] = wr_val;
        default:     coef_nxt = coef_r;
      endcase
    end
  end

  // b0 resets to one, every other coefficient to zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '{b: {{((NUM_B-1)*COEF_W){1'b0}}, COEF_B0_RST}, a: '0};
    end else begin
      coef_r <= coef_nxt;
    end
  end

  // read back
  always_comb begin
    unique case (reg_idx)
      REG_COEF_B0: rd_val = coef_r.b[0];
      REG_COEF_B1: rd_val = coef_r.b[1];
      REG_COEF_B2: rd_val = coef_r.b[2];
      REG_COEF_B3: rd_val = coef_r.b[3];
      REG_COEF_A1: rd_val = coef_r.a[0];
      REG_COEF_A2: rd_val = coef_r.a[1];
      REG_COEF_A3: rd_val = coef_r.a[2];
      default:     rd_val = '0;
    endcase
  end

  assign prdata = {{(PDATA_W-COEF_W){rd_val[COEF_W-1]}}, rd_val};
  assign coefs  = coef_r;

endmodule

`default_nettype wire

FILE: rtl/iirdf2_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_ctrl
// sequencer for the shared multiply-accumulate: feedback pass, w0, feedforward
// ----------------------------------------------------------------------------
module iirdf2_ctrl import iirdf2_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output      logic     in_ready,
  input  wire dp_stat_t stat,
  output      dp_cmd_t  cmd
);

  state_t           state_r;
  state_t           state_nxt;
  logic [IDX_W-1:0] cnt_r;
  logic [IDX_W-1:0] cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    cmd         = '0;
    cmd.tap_idx = cnt_r;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load    = 1'b1;
          cmd.acc_clr = 1'b1;
          cnt_nxt     = '0;
          state_nxt   = ST_FB;
        end
      end
      ST_FB: begin
        cmd.mul_en = 1'b1;
        cmd.fb_sel = 1'b1;
        if (cnt_r == IDX_W'(ORDER - 1)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FB_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FB_END: begin
        state_nxt = ST_W0;
      end
      ST_W0: begin
        cmd.w0_en   = 1'b1;
        cmd.acc_clr = 1'b1;
        cnt_nxt     = '0;
        state_nxt   = ST_FF;
      end
      ST_FF: begin
        cmd.mul_en = 1'b1;
        if (cnt_r == IDX_W'(ORDER)) begin
          cnt_nxt   = '0;
          state_nxt = ST_FF_END;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_FF_END: begin
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (stat.out_free) begin
          cmd.done_en = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/iirdf2_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iirdf2_dp
// shared multiplier, accumulator, rounding and saturation, delay line and
// output register
// ----------------------------------------------------------------------------
module iirdf2_dp import iirdf2_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire dp_cmd_t                    cmd,
  output      dp_stat_t                   stat,
  input  wire coef_set_t                  coefs,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_last_of_block,
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic signed [SAMPLE_W-1:0] out_sample_out,
  output      logic                       out_overflow
);

  localparam int DIFF_W = RND_W + 1;
  localparam logic signed [DIFF_W-1:0] W_HI = DIFF_W'(W_MAX);
  localparam logic signed [DIFF_W-1:0] W_LO = DIFF_W'(W_MIN);
  localparam logic signed [RND_W-1:0]  Y_HI = RND_W'(Y_MAX);
  localparam logic signed [RND_W-1:0]  Y_LO = RND_W'(Y_MIN);

  logic signed [SAMPLE_W-1:0] x_r;
  logic                       last_r;
  logic signed [STATE_W-1:0]  dly_r [ORDER];
  logic signed [STATE_W-1:0]  w0_r;
  logic                       ovf_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic                       add_r;
  logic signed [ACC_W-1:0]    acc_r;
  logic                       out_valid_r;
  logic signed [SAMPLE_W-1:0] sample_out_r;
  logic                       overflow_r;

  logic signed [COEF_W-1:0]   coef_sel;
  logic signed [STATE_W-1:0]  tap_sel;
  logic signed [ACC_W-1:0]    acc_half;
  logic signed [RND_W-1:0]    rnd;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [STATE_W-1:0]  w0_sat;
  logic                       w0_ovf;
  logic signed [SAMPLE_W-1:0] y_sat;
  logic                       y_ovf;

  // operand select for the shared multiplier
  always_comb begin
    coef_sel = '0;
    tap_sel  = '0;
    if (cmd.fb_sel) begin
      for (int k = 0; k < ORDER; k++) begin
        if (cmd.tap_idx == IDX_W'(k)) begin
          coef_sel = coefs.a[k];
          tap_sel  = dly_r[k];
        end
      end
    end else begin
      if (cmd.tap_idx == '0) begin
        coef_sel = coefs.b[0];
        tap_sel  = w0_r;
      end
      for (int k = 1; k <= ORDER; k++) begin
        if (cmd.tap_idx == IDX_W'(k)) begin
          coef_sel = coefs.b[k];
          tap_sel  = dly_r[k-1];
        end
      end
    end
  end

  // product register and accumulator
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod_r <= coef_sel * tap_sel;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_r <= 1'b0;
    end else begin
      add_r <= cmd.mul_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (add_r) begin
      acc_r <= acc_r + ACC_W'(prod_r);
    end
  end

  // round half up, then floor shift
  assign acc_half = acc_r + ACC_W'(HALF_LSB);
  assign rnd      = acc_half[ACC_W-1:FRAC_BITS];

  // w0 = x - round(feedback sum), saturated to the state width
  always_comb begin
    diff   = DIFF_W'(x_r) - DIFF_W'(rnd);
    w0_ovf = 1'b0;
    if (diff > W_HI) begin
      w0_sat = STATE_W'(W_MAX);
      w0_ovf = 1'b1;
    end else if (diff < W_LO) begin
      w0_sat = STATE_W'(W_MIN);
      w0_ovf = 1'b1;
    end else begin
      w0_sat = diff[STATE_W-1:0];
    end
  end

  // output saturation
  always_comb begin
    y_ovf = 1'b0;
    if (rnd > Y_HI) begin
      y_sat = SAMPLE_W'(Y_MAX);
      y_ovf = 1'b1;
    end else if (rnd < Y_LO) begin
      y_sat = SAMPLE_W'(Y_MIN);
      y_ovf = 1'b1;
    end else begin
      y_sat = rnd[SAMPLE_W-1:0];
    end
  end

  // input capture and w0 register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= in_sample_in;
      last_r <= in_last_of_block;
    end
    if (cmd.w0_en) begin
      w0_r  <= w0_sat;
      ovf_r <= w0_ovf;
    end
  end

  // delay line, aged at the end of each sample, or cleared after the last sample of a block
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < ORDER; k++) begin
        dly_r[k] <= '0;
      end
    end else if (cmd.done_en) begin
      if (last_r) begin
        for (int k = 0; k < ORDER; k++) begin
          dly_r[k] <= '0;
        end
      end else begin
        dly_r[0] <= w0_r;
        for (int k = 1; k < ORDER; k++) begin
          dly_r[k] <= dly_r[k-1];
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.done_en) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.done_en) begin
      sample_out_r <= y_sat;
      overflow_r   <= ovf_r | y_ovf;
    end
  end

  assign stat.out_free  = ~out_valid_r | out_ready;
  assign out_valid      = out_valid_r;
  assign out_sample_out = sample_out_r;
  assign out_overflow   = overflow_r;

endmodule

`default_nettype wire

FILE: rtl/iir_filter_direct_form_two_core.sv
// each sample runs a feedback pass, a w0 update and a feedforward pass in turn before
// its result is registered; a new input beat is taken only after that, since the
//   single shared multiplier takes ORDER feedback and ORDER+1 feedforward terms
// a finished result waits in the output register while the next sample starts
// reset: synchronous, active low; delay line cleared, b0 = 1.0, others zero
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// iir_filter_direct_form_two_core
// direct form ii iir filter with apb coefficient registers
// ----------------------------------------------------------------------------
module iir_filter_direct_form_two_core import iirdf2_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [PADDR_W-1:0]         paddr,
  input  wire logic [PDATA_W-1:0]         pwdata,
  output      logic [PDATA_W-1:0]         prdata,
  output      logic                       pready,
  // input samples
  input  wire logic                       in_valid,
  output      logic                       in_ready,
  input  wire logic signed [SAMPLE_W-1:0] in_sample_in,
  input  wire logic                       in_last_of_block,
  // results
  output      logic                       out_valid,
  input  wire logic                       out_ready,
  output      logic signed [SAMPLE_W-1:0] out_sample_out,
  output      logic                       out_overflow
);

  coef_set_t coefs;
  dp_cmd_t   cmd;
  dp_stat_t  stat;

  // coefficient registers
  iirdf2_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .coefs   (coefs)
  );

  // sequencer
  iirdf2_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // arithmetic and state
  iirdf2_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .coefs            (coefs),
    .in_sample_in     (in_sample_in),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_overflow     (out_overflow)
  );

endmodule

`default_nettype wire

FILE: sim/iir_filter_direct_form_two_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iir_filter_direct_form_two_core_tb
// drives samples through the direct form ii filter under several coefficient
// sets, predicts each filtered beat in fixed point and compares it field by
// field; coefficients go in over the register port and are read back
// ----------------------------------------------------------------------------
module iir_filter_direct_form_two_core_tb;
  import iirdf2_pkg::*;

  localparam int NUM_REGS       = NUM_B + NUM_A;
  localparam int UNMAPPED_IDX   = NUM_REGS;
  localparam int SETTLE_CYCLES  = 16;
  localparam int TAIL_CYCLES    = 32;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int ITEMS_PER_SET  = 142;
  localparam int NUM_RAND_SETS  = 9;

  // extreme coefficient and sample patterns
  localparam logic [COEF_W-1:0]          COEF_MAX = COEF_W'(W_MAX);
  localparam logic [COEF_W-1:0]          COEF_MIN = COEF_W'(W_MIN);
  localparam logic signed [SAMPLE_W-1:0] X_MAX    = SAMPLE_W'(Y_MAX);
  localparam logic signed [SAMPLE_W-1:0] X_MIN    = SAMPLE_W'(Y_MIN);

  typedef enum {
    CS_FIR,
    CS_STABLE,
    CS_GENTLE,
    CS_WILD,
    CS_ALL_MAX,
    CS_ALL_MIN
  } coef_style_t;

  typedef struct {
    logic signed [SAMPLE_W-1:0] sample;
    logic                       ovf;
  } filt_result_t;

  // filter predictor and store of expected beats
  class iir_scoreboard;
    logic signed [COEF_W-1:0] coef [NUM_REGS];
    longint                   dline [ORDER];
    filt_result_t             expected_q [$];
    int                       errors;

    function new();
      foreach (coef[i]) coef[i] = '0;
      coef[REG_COEF_B0] = COEF_B0_RST;
      foreach (dline[i]) dline[i] = 0;
      errors = 0;
    endfunction

    function void set_coef(int idx, logic [COEF_W-1:0] val);
      if (idx >= REG_COEF_B0 && idx <= REG_COEF_A3) coef[idx] = val;
    endfunction

    // round half up, then drop the q20 fraction
    function longint round_q20(longint acc);
      return (acc + HALF_LSB) >>> FRAC_BITS;
    endfunction

    function longint clamp(longint v, longint lo, longint hi, inout bit ovf);
      if (v > hi) begin
        ovf = 1'b1;
        return hi;
      end
      if (v < lo) begin
        ovf = 1'b1;
        return lo;
      end
      return v;
    endfunction

    function void note_sample(logic signed [SAMPLE_W-1:0] x, logic last);
      longint       acc;
      longint       w0;
      longint       y;
      bit           ovf;
      filt_result_t r;
      ovf = 1'b0;
      // feedback sum over the aged delay line
      acc = 0;
      for (int k = 1; k <= ORDER; k++)
        acc += longint'(coef[REG_COEF_A1 + k - 1]) * dline[k-1];
      w0 = clamp(longint'(x) - round_q20(acc), W_MIN, W_MAX, ovf);
      // feedforward sum from the saturated w0
      acc = longint'(coef[REG_COEF_B0]) * w0;
      for (int k = 1; k <= ORDER; k++)
        acc += longint'(coef[REG_COEF_B0 + k]) * dline[k-1];
      y = clamp(round_q20(acc), Y_MIN, Y_MAX, ovf);
      // shift in w0, or clear at block end
      for (int k = ORDER - 1; k > 0; k--)
        dline[k] = last ? 0 : dline[k-1];
      dline[0] = last ? 0 : w0;
      r.sample = y[SAMPLE_W-1:0];
      r.ovf    = ovf;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] y, logic ovf);
      filt_result_t r;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat: sample_out %0d overflow %0b", $time, y, ovf);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (y !== r.sample) begin
        $display("%0t: sample_out expected %0d actual %0d", $time, r.sample, y);
        errors++;
      end
      if (ovf !== r.ovf) begin
        $display("%0t: overflow expected %0b actual %0b", $time, r.ovf, ovf);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst_n;
  logic                       psel;
  logic                       penable;
  logic                       pwrite;
  logic [PADDR_W-1:0]         paddr;
  logic [PDATA_W-1:0]         pwdata;
  logic [PDATA_W-1:0]         prdata;
  logic                       pready;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       in_last_of_block;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       out_overflow;

  iir_scoreboard sb = new();
  bit            burst_mode;
  int unsigned   cycle_count = 0;
  coef_style_t   set_plan [NUM_RAND_SETS] = '{CS_STABLE, CS_FIR, CS_WILD, CS_ALL_MAX,
                                              CS_STABLE, CS_ALL_MIN, CS_GENTLE, CS_FIR,
                                              CS_WILD};

  iir_filter_direct_form_two_core u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_sample_in     (in_sample_in),
    .in_last_of_block (in_last_of_block),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_sample_out   (out_sample_out),
    .out_overflow     (out_overflow)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("iir_filter_direct_form_two_core_tb: FAIL");
      $finish;
    end
  end

  // register write, setup then access
  task automatic apb_write(input int idx, input logic [COEF_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'(idx * 4);
    pwdata  <= {{(PDATA_W-COEF_W){val[COEF_W-1]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.set_coef(idx, val);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apb_read(input int idx, output logic [PDATA_W-1:0] rd);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= PADDR_W'(idx * 4);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // read back every coefficient against the predictor copy
  task automatic check_regs();
    logic [PDATA_W-1:0] rd;
    for (int i = REG_COEF_B0; i <= REG_COEF_A3; i++) begin
      apb_read(i, rd);
      if (rd[COEF_W-1:0] !== sb.coef[i]) begin
        $display("%0t: register %0d expected %0h actual %0h", $time, i,
                 sb.coef[i], rd[COEF_W-1:0]);
        sb.errors++;
      end
    end
  endtask

  task automatic load_coefs(input logic [COEF_W-1:0] b0, input logic [COEF_W-1:0] b1,
                            input logic [COEF_W-1:0] b2, input logic [COEF_W-1:0] b3,
                            input logic [COEF_W-1:0] a1, input logic [COEF_W-1:0] a2,
                            input logic [COEF_W-1:0] a3);
    apb_write(REG_COEF_B0, b0);
    apb_write(REG_COEF_B1, b1);
    apb_write(REG_COEF_B2, b2);
    apb_write(REG_COEF_B3, b3);
    apb_write(REG_COEF_A1, a1);
    apb_write(REG_COEF_A2, a2);
    apb_write(REG_COEF_A3, a3);
    // a write past the map must change nothing
    apb_write(UNMAPPED_IDX, COEF_W'($urandom));
    check_regs();
  endtask

  // range 0 means any 24-bit pattern
  function automatic logic [COEF_W-1:0] draw_coef(int range);
    if (range == 0) return COEF_W'($urandom);
    return COEF_W'(int'($urandom_range(0, 2 * range)) - range);
  endfunction

  task automatic load_style(input coef_style_t style);
    case (style)
      CS_FIR: begin
        load_coefs(draw_coef(1 << 21), draw_coef(1 << 21), draw_coef(1 << 21),
                   draw_coef(1 << 21), '0, '0, '0);
      end
      CS_STABLE: begin
        load_coefs(draw_coef(1 << 20), draw_coef(1 << 20), draw_coef(1 << 20),
                   draw_coef(1 << 20), draw_coef(1 << 18), draw_coef(1 << 18),
                   draw_coef(1 << 18));
      end
      CS_GENTLE: begin
        load_coefs(draw_coef(1 << 19), draw_coef(1 << 19), draw_coef(1 << 19),
                   draw_coef(1 << 19), draw_coef(1 << 20), draw_coef(1 << 20),
                   draw_coef(1 << 20));
      end
      CS_WILD: begin
        load_coefs(draw_coef(0), draw_coef(0), draw_coef(0), draw_coef(0),
                   draw_coef(0), draw_coef(0), draw_coef(0));
      end
      CS_ALL_MAX: begin
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
      end
      default: begin
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
      end
    endcase
  endtask

  function automatic logic signed [SAMPLE_W-1:0] draw_sample();
    int pick;
    pick = $urandom_range(0, 9);
    case (pick)
      0: begin
        case ($urandom_range(0, 4))
          0: return X_MAX;
          1: return X_MIN;
          2: return 0;
          3: return 1;
          default: return -1;
        endcase
      end
      1, 2: return SAMPLE_W'(int'($urandom_range(0, 512)) - 256);
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // one input beat, with a random lead-in gap outside burst mode
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic last);
    int gap;
    gap = burst_mode ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_sample_in     <= x;
    in_last_of_block <= last;
    do @(posedge clk); while (!in_ready);
    sb.note_sample(x, last);
  endtask

  // hold off the sender until every expected beat is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // result side with random stalls outside burst mode
  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      stall = burst_mode ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      sb.check_result(out_sample_out, out_overflow);
    end
  end

  // stimulus
  initial begin
    burst_mode       = 1'b0;
    rst_n            <= 1'b0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    in_valid         <= 1'b0;
    in_sample_in     <= '0;
    in_last_of_block <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    // reset coefficients pass samples straight through
    send_sample(X_MAX, 1'b0);
    send_sample(X_MIN, 1'b0);
    send_sample(0, 1'b0);
    send_sample(1, 1'b1);
    send_sample(-1, 1'b0);
    settle();

    // b0 of one half: ties round toward plus infinity
    load_coefs(COEF_W'(HALF_LSB), '0, '0, '0, '0, '0, '0);
    send_sample(1, 1'b0);
    send_sample(-1, 1'b0);
    send_sample(3, 1'b0);
    send_sample(-3, 1'b1);
    settle();

    // extreme coefficients: runaway feedback saturates w0 and the output
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MIN, COEF_MAX, COEF_MIN);
    repeat (6) send_sample(X_MAX, 1'b0);
    repeat (3) send_sample(X_MIN, 1'b0);
    send_sample(100, 1'b1);
    settle();

    // fir mode impulse, cleared by block end
    load_coefs(COEF_W'(1 << FRAC_BITS), COEF_W'(2 << FRAC_BITS), -COEF_W'(1 << FRAC_BITS),
               COEF_W'(HALF_LSB), '0, '0, '0);
    send_sample(1000, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b0);
    send_sample(0, 1'b1);
    send_sample(0, 1'b0);
    settle();

    // random samples under a run of coefficient sets
    for (int p = 0; p < NUM_RAND_SETS; p++) begin
      load_style(set_plan[p]);
      burst_mode = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < ITEMS_PER_SET; i++) begin
        if (i % 32 == 31) burst_mode = ($urandom_range(0, 2) == 0);
        if ((p == 0 && i == 70) || $urandom_range(0, 63) == 0) drain_results();
        send_sample(draw_sample(), $urandom_range(0, 19) == 0);
      end
      burst_mode = 1'b0;
      settle();
    end

    // wind down
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("iir_filter_direct_form_two_core_tb: PASS");
    end else begin
      $display("iir_filter_direct_form_two_core_tb: FAIL");
    end
    $finish;
  end

endmodule
